FILE: rtl/tmcc_dbpsk_frame_sync_unit_macros.svh
// assertion macros of the tmcc frame sync rtl
// no dependencies; included by files that carry concurrent checks
`ifndef TMCC_DBPSK_FRAME_SYNC_UNIT_MACROS_SVH
`define TMCC_DBPSK_FRAME_SYNC_UNIT_MACROS_SVH

// plain property check, disabled while reset is asserted
`define TMCC_ASSERT(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) \
        else $error(msg);

// antecedent in one cycle, consequent in the next
`define TMCC_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/tmcc_pkg.sv
// shared types and constants of the tmcc dbpsk frame sync unit
// no dependencies; used by the controller, the datapath and the top level
package tmcc_pkg;

    localparam int FRAME_BITS  = 204;
    localparam int SYNC_LEN    = 16;
    localparam int CODE_N      = 273;
    localparam int CODE_K      = 191;
    localparam int CODE_R      = CODE_N - CODE_K;
    localparam int LEAD_ZEROS  = 89;
    localparam int DATA_START  = 20;
    localparam int GATE_COUNT  = 203;
    localparam int PARITY_TAPS = CODE_K + 1;
    localparam int SYND_W      = $clog2(CODE_R);
    localparam int CNT_W       = 8;
    localparam int MODE_W      = 2;

    // transmission mode codes
    localparam logic [MODE_W-1:0] MODE_1 = 2'd1;
    localparam logic [MODE_W-1:0] MODE_2 = 2'd2;
    localparam logic [MODE_W-1:0] MODE_3 = 2'd3;

    // sync words, element 0 is history bit 1
    localparam logic [0:SYNC_LEN-1] SYNC_EVEN = 16'b0011010111101110;
    localparam logic [0:SYNC_LEN-1] SYNC_ODD  = 16'b1100101000010001;

    // check polynomial taps of the shortened difference-set code
    localparam logic [0:PARITY_TAPS-1] CHECK_TAPS = {
        24'b100010001010100010000010,
        24'b100010000010000000001010,
        24'b100010100000001010111011,
        24'b000111110011010010000101,
        24'b011101110010111110100001,
        24'b111101011010011100011000,
        24'b010000100011001010100101,
        24'b111101100001110001100001
    };

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic car_step;
        logic shift;
        logic synd_step;
        logic finish;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic last_car;
        logic check_hit;
        logic synd_last;
        logic out_free;
    } stat_t;

endpackage

FILE: rtl/tmcc_intf.sv
// request channel interfaces of the tmcc frame sync unit
// no dependencies; symbol request channel and result request channel
interface tmcc_sym_if #(
    parameter int SAMPLE_BITS = 12
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] c0_re;
    logic signed [SAMPLE_BITS-1:0] c0_im;
    logic signed [SAMPLE_BITS-1:0] c1_re;
    logic signed [SAMPLE_BITS-1:0] c1_im;
    logic signed [SAMPLE_BITS-1:0] c2_re;
    logic signed [SAMPLE_BITS-1:0] c2_im;
    logic signed [SAMPLE_BITS-1:0] c3_re;
    logic signed [SAMPLE_BITS-1:0] c3_im;

    modport source (
        output valid, c0_re, c0_im, c1_re, c1_im, c2_re, c2_im, c3_re, c3_im,
        input  ready
    );
    modport sink (
        input  valid, c0_re, c0_im, c1_re, c1_im, c2_re, c2_im, c3_re, c3_im,
        output ready
    );
endinterface

interface tmcc_res_if;
    logic valid;
    logic ready;
    logic tmcc_bit;
    logic frame_end;
    logic parity_fail;

    modport source (
        output valid, tmcc_bit, frame_end, parity_fail,
        input  ready
    );
    modport sink (
        input  valid, tmcc_bit, frame_end, parity_fail,
        output ready
    );
endinterface

FILE: rtl/tmcc_ctrl.sv
// sequencing state machine of the tmcc frame sync unit
// depends on tmcc_pkg for the command and status structs
module tmcc_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  tmcc_pkg::stat_t stat,
    output tmcc_pkg::cmd_t  cmd
);
    import tmcc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CARR  = 5'b00010,
        S_SHIFT = 5'b00100,
        S_SYND  = 5'b01000,
        S_FIN   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CARR;
                end
            end
            S_CARR:
            begin
                cmd.car_step = 1'b1;
                if (stat.last_car)
                begin
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (stat.check_hit)
                begin
                    state_next = S_SYND;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_SYND:
            begin
                cmd.synd_step = 1'b1;
                if (stat.synd_last)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/tmcc_dp.sv
// datapath of the tmcc frame sync unit: detection, history, syndrome check
// depends on tmcc_pkg and on the assertion macro header
`include "tmcc_dbpsk_frame_sync_unit_macros.svh"

module tmcc_dp #(
    parameter int MAX_CARRIERS = 4,
    parameter int SAMPLE_BITS  = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [tmcc_pkg::MODE_W-1:0]   cfg_wdata,
    input  logic signed [SAMPLE_BITS-1:0] c0_re,
    input  logic signed [SAMPLE_BITS-1:0] c0_im,
    input  logic signed [SAMPLE_BITS-1:0] c1_re,
    input  logic signed [SAMPLE_BITS-1:0] c1_im,
    input  logic signed [SAMPLE_BITS-1:0] c2_re,
    input  logic signed [SAMPLE_BITS-1:0] c2_im,
    input  logic signed [SAMPLE_BITS-1:0] c3_re,
    input  logic signed [SAMPLE_BITS-1:0] c3_im,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic                          out_bit,
    output logic                          out_fe,
    output logic                          out_pf,
    input  tmcc_pkg::cmd_t                cmd,
    output tmcc_pkg::stat_t               stat
);
    import tmcc_pkg::*;

    localparam int CAR_W = (MAX_CARRIERS > 1) ? $clog2(MAX_CARRIERS) : 1;
    localparam int PROD_W = 2 * SAMPLE_BITS;
    localparam logic [2:0] MAX_CAR = 3'(MAX_CARRIERS);

    logic [MODE_W-1:0]            mode_reg;
    logic signed [SAMPLE_BITS-1:0] cap_re_reg [4];
    logic signed [SAMPLE_BITS-1:0] cap_im_reg [4];
    logic signed [SAMPLE_BITS-1:0] prev_re_reg [MAX_CARRIERS];
    logic signed [SAMPLE_BITS-1:0] prev_im_reg [MAX_CARRIERS];
    logic [CAR_W-1:0]             k_reg;
    logic [2:0]                   neg_reg;
    logic [2:0]                   ncar_reg;
    logic [2:0]                   ncar_next;
    logic [2:0]                   ncar_raw;
    logic [FRAME_BITS-1:0]        hist_reg;
    logic [FRAME_BITS-1:0]        hist_next;
    logic                         bit_reg;
    logic                         bit_next;
    logic                         hit_reg;
    logic                         fail_reg;
    logic [CODE_N-1:0]            work_reg;
    logic [SYND_W-1:0]            j_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic                         out_valid_reg;
    logic                         out_bit_reg;
    logic                         out_fe_reg;
    logic                         out_pf_reg;

    logic signed [SAMPLE_BITS-1:0] xr;
    logic signed [SAMPLE_BITS-1:0] xi;
    logic signed [PROD_W-1:0]      p_re;
    logic signed [PROD_W-1:0]      p_im;
    logic [PROD_W:0]               dot;
    logic                          gate_open;
    logic                          sync_even_ok;
    logic                          sync_odd_ok;
    logic                          parity;

    // carrier count from the mode, capped by the build
    always_comb
    begin
        case (mode_reg)
            MODE_2:  ncar_raw = 3'd2;
            MODE_3:  ncar_raw = 3'd4;
            default: ncar_raw = 3'd1;
        endcase
        ncar_next = (ncar_raw > MAX_CAR) ? MAX_CAR : ncar_raw;
    end

    // differential detection of the selected carrier
    assign xr   = cap_re_reg[k_reg];
    assign xi   = cap_im_reg[k_reg];
    assign p_re = xr * prev_re_reg[k_reg];
    assign p_im = xi * prev_im_reg[k_reg];
    assign dot  = {p_re[PROD_W-1], p_re} + {p_im[PROD_W-1], p_im};

    // majority vote, a tie gives zero
    assign bit_next  = ({neg_reg, 1'b0} > {1'b0, ncar_reg});
    assign hist_next = {bit_next, hist_reg[FRAME_BITS-1:1]};
    assign gate_open = (cnt_reg >= CNT_W'(GATE_COUNT));

    // sync word compare on the shifted history
    always_comb
    begin
        sync_even_ok = 1'b1;
        sync_odd_ok  = 1'b1;
        for (int i = 0; i < SYNC_LEN; i++)
        begin
            if (hist_next[1 + i] != SYNC_EVEN[i])
            begin
                sync_even_ok = 1'b0;
            end
            if (hist_next[1 + i] != SYNC_ODD[i])
            begin
                sync_odd_ok = 1'b0;
            end
        end
    end

    // one syndrome over the current code window
    always_comb
    begin
        parity = 1'b0;
        for (int i = 0; i < PARITY_TAPS; i++)
        begin
            parity = parity ^ (work_reg[i] & CHECK_TAPS[i]);
        end
    end

    // status back to the controller
    always_comb
    begin
        stat.last_car  = (3'(k_reg) == (ncar_reg - 3'd1));
        stat.check_hit = gate_open && (sync_even_ok || sync_odd_ok);
        stat.synd_last = (j_reg == SYND_W'(CODE_R - 1));
        stat.out_free  = !out_valid_reg || out_ready;
    end

    // mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_1;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_wdata;
        end
    end

    // captured symbol samples
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cap_re_reg[0] <= c0_re;
            cap_im_reg[0] <= c0_im;
            cap_re_reg[1] <= c1_re;
            cap_im_reg[1] <= c1_im;
            cap_re_reg[2] <= c2_re;
            cap_im_reg[2] <= c2_im;
            cap_re_reg[3] <= c3_re;
            cap_im_reg[3] <= c3_im;
            ncar_reg      <= ncar_next;
        end
    end

    // previous samples, carrier counter and vote count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < MAX_CARRIERS; c++)
            begin
                prev_re_reg[c] <= '0;
                prev_im_reg[c] <= '0;
            end
            k_reg   <= '0;
            neg_reg <= '0;
        end
        else if (cmd.load)
        begin
            k_reg   <= '0;
            neg_reg <= '0;
        end
        else if (cmd.car_step)
        begin
            prev_re_reg[k_reg] <= xr;
            prev_im_reg[k_reg] <= xi;
            k_reg              <= k_reg + CAR_W'(1);
            neg_reg            <= neg_reg + {2'b00, dot[PROD_W]};
        end
    end

    // history, syndrome sequencer and symbol counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg <= '0;
            hit_reg  <= 1'b0;
            fail_reg <= 1'b0;
            j_reg    <= '0;
            cnt_reg  <= CNT_W'(GATE_COUNT);
        end
        else
        begin
            if (cmd.shift)
            begin
                hist_reg <= hist_next;
                hit_reg  <= stat.check_hit;
                fail_reg <= 1'b0;
                j_reg    <= '0;
            end
            else if (cmd.synd_step)
            begin
                fail_reg <= fail_reg | parity;
                j_reg    <= j_reg + SYND_W'(1);
            end
            if (cmd.finish)
            begin
                if (hit_reg && !fail_reg)
                begin
                    cnt_reg <= '0;
                end
                else if (cnt_reg < CNT_W'(GATE_COUNT))
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
            end
        end
    end

    // code window: leading zeros then history bits from the data start
    always_ff @(posedge clk)
    begin
        if (cmd.shift)
        begin
            work_reg <= {hist_next[FRAME_BITS-1:DATA_START], {LEAD_ZEROS{1'b0}}};
            bit_reg  <= bit_next;
        end
        else if (cmd.synd_step)
        begin
            work_reg <= {1'b0, work_reg[CODE_N-1:1]};
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_bit_reg <= bit_reg;
            out_fe_reg  <= hit_reg && !fail_reg;
            out_pf_reg  <= hit_reg && fail_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_bit   = out_bit_reg;
    assign out_fe    = out_fe_reg;
    assign out_pf    = out_pf_reg;

    // checks
    `TMCC_ASSERT(a_fe_pf_excl, clk, rst_n, out_valid_reg |-> !(out_fe_reg && out_pf_reg), "frame end and parity fail both set")
    `TMCC_ASSERT(a_cnt_sat, clk, rst_n, cnt_reg <= CNT_W'(GATE_COUNT), "symbol counter beyond saturation")
    `TMCC_ASSERT(a_synd_needs_hit, clk, rst_n, cmd.synd_step |-> hit_reg, "syndrome step without sync hit")
    `TMCC_ASSERT_NEXT(a_cnt_clear, clk, rst_n, cmd.finish && hit_reg && !fail_reg, cnt_reg == '0, "counter not cleared on frame end")

endmodule

FILE: rtl/tmcc_dbpsk_frame_sync_unit.sv
// top level of the tmcc dbpsk frame sync unit
// depends on tmcc_pkg, tmcc_intf, tmcc_ctrl and tmcc_dp
//
// One request per OFDM symbol carries the TMCC pilot samples of up to four
// carriers; each request yields one result with the voted DBPSK bit, a frame
// end flag and a parity fail flag. A request runs the load, one carrier step
// per carrier in use (1, 2 or 4), the history shift, the syndrome steps when
// the symbol counter is open and the sync word matches, and the finish: the
// carrier loop runs one complex product per cycle and the parity check
// evaluates one of the 82 syndromes of the (273,191) code per cycle. A new
// request is taken while the previous result still waits in the output
// register. The mode register is written through cfg_we and cfg_wdata.
module tmcc_dbpsk_frame_sync_unit #(
    parameter int MAX_CARRIERS = 4,
    parameter int SAMPLE_BITS  = 12
) (
    input  logic                        clk,
    input  logic                        rst_n,
    tmcc_sym_if.sink                    sym,
    tmcc_res_if.source                  res,
    input  logic                        cfg_we,
    input  logic [tmcc_pkg::MODE_W-1:0] cfg_wdata
);
    import tmcc_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    logic  in_ready;
    logic  out_valid;
    logic  out_bit;
    logic  out_fe;
    logic  out_pf;

    // sequencer
    tmcc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sym.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath
    tmcc_dp #(
        .MAX_CARRIERS (MAX_CARRIERS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .c0_re     (sym.c0_re),
        .c0_im     (sym.c0_im),
        .c1_re     (sym.c1_re),
        .c1_im     (sym.c1_im),
        .c2_re     (sym.c2_re),
        .c2_im     (sym.c2_im),
        .c3_re     (sym.c3_re),
        .c3_im     (sym.c3_im),
        .out_ready (res.ready),
        .out_valid (out_valid),
        .out_bit   (out_bit),
        .out_fe    (out_fe),
        .out_pf    (out_pf),
        .cmd       (cmd),
        .stat      (stat)
    );

    // channel outputs
    assign sym.ready       = in_ready;
    assign res.valid       = out_valid;
    assign res.tmcc_bit    = out_bit;
    assign res.frame_end   = out_fe;
    assign res.parity_fail = out_pf;

endmodule
